// ===== design/rect_occlusion_cull_defines.svh =====
// assertion macros shared by the occlusion cull design files
`ifndef RECT_OCCLUSION_CULL_DEFINES_SVH
`define RECT_OCCLUSION_CULL_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define ROC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define ROC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/roc_pkg.sv =====
// types and constants for the rectangle occlusion cull block
package roc_pkg;

    localparam int MAX_SURFACES = 64;
    localparam int CNT_W        = $clog2(MAX_SURFACES + 1);
    localparam logic [6:0] TOTAL_MAX = 7'd127;

    typedef struct packed {
        logic               frame_start;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [14:0]        rect_width;
        logic [14:0]        rect_height;
        logic               is_opaque;
    } in_item_t;

    typedef struct packed {
        logic       occluded;
        logic [6:0] occluded_so_far;
        logic       store_full;
    } out_item_t;

    // stored occluder, kept as edges
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [16:0] right;
        logic signed [16:0] bottom;
    } occ_rect_t;

    // item traveling down the cell chain
    typedef struct packed {
        logic             valid;
        logic             frame_start;
        occ_rect_t        rect;
        logic [CNT_W-1:0] remaining;
        logic             store;
        logic             occ;
        logic             full;
    } tok_t;

endpackage

// ===== design/rect_occlusion_cull.sv =====
// an accepted item passes through every chain cell register, then the output register
// throughput: one item per cycle while the result is not stalled; each cell holds one occluder and the item
// walks the cell chain one cell a cycle, so later items see earlier stores
// a stalled result freezes the whole chain and the input stalls with it
// reset clears counters, flags and valid bits; stored rectangles are not
// cleared, entries beyond the per-frame occluder count are never tested
module rect_occlusion_cull import roc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      surf_valid,
    output logic      surf_stall,
    input  in_item_t  surf,
    output logic      cull_valid,
    input  logic      cull_stall,
    output out_item_t cull
);

    tok_t chain [MAX_SURFACES+1];
    logic en;

    assign surf_stall = !en;

    roc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .surf_valid (surf_valid),
        .surf       (surf),
        .tok        (chain[0])
    );

    for (genvar g = 0; g < MAX_SURFACES; g++)
    begin : g_cell
        roc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    roc_tail u_tail (
        .clk        (clk),
        .rst_n      (rst_n),
        .tok_in     (chain[MAX_SURFACES]),
        .cull_stall (cull_stall),
        .en         (en),
        .cull_valid (cull_valid),
        .cull       (cull)
    );

endmodule

// ===== design/roc_front.sv =====
// entry stage: occluder count, store slot and full flag per frame
`include "rect_occlusion_cull_defines.svh"

module roc_front import roc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     surf_valid,
    input  in_item_t surf,
    output tok_t     tok
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic [CNT_W-1:0] cnt_base;
    logic             ovf_base;
    logic             store;
    logic             accept;

    assign accept = surf_valid && en;

    always_comb
    begin
        cnt_base   = surf.frame_start ? '0 : count_reg;
        ovf_base   = surf.frame_start ? 1'b0 : ovf_reg;
        store      = surf.is_opaque && (cnt_base < CNT_W'(MAX_SURFACES));
        count_next = cnt_base + CNT_W'(store);
        ovf_next   = ovf_base || (surf.is_opaque && !store);

        tok.valid       = surf_valid;
        tok.frame_start = surf.frame_start;
        tok.rect.left   = surf.rect_x;
        tok.rect.top    = surf.rect_y;
        tok.rect.right  = $signed({surf.rect_x[15], surf.rect_x})
                        + $signed({2'b00, surf.rect_width});
        tok.rect.bottom = $signed({surf.rect_y[15], surf.rect_y})
                        + $signed({2'b00, surf.rect_height});
        tok.remaining   = cnt_base;
        tok.store       = store;
        tok.occ         = 1'b0;
        tok.full        = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    `ROC_ASSERT_NEXT(a_full_sets_ovf,
        accept && !surf.frame_start && surf.is_opaque &&
        count_reg == CNT_W'(MAX_SURFACES),
        ovf_reg && count_reg == CNT_W'(MAX_SURFACES),
        "opaque item on full store did not raise overflow")
    `ROC_ASSERT_NEXT(a_frame_restart,
        accept && surf.frame_start,
        count_reg == CNT_W'($past(surf.is_opaque)),
        "frame start did not restart the occluder count")

endmodule

// ===== design/roc_cell.sv =====
// one chain cell: holds one occluder and tests the passing item against it
module roc_cell import roc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  tok_t tok_in,
    output tok_t tok_out
);

    occ_rect_t rect_reg;
    occ_rect_t rect_next;
    tok_t      tok_reg;
    tok_t      tok_next;
    logic      valid_reg;
    logic      hit;

    always_comb
    begin
        rect_next = rect_reg;
        tok_next  = tok_in;
        // only cells below the item's occluder count hold live entries
        hit = tok_in.valid && (tok_in.remaining != '0)
            && (rect_reg.left <= tok_in.rect.left)
            && (rect_reg.top <= tok_in.rect.top)
            && (rect_reg.right >= tok_in.rect.right)
            && (rect_reg.bottom >= tok_in.rect.bottom);
        if (hit)
        begin
            tok_next.occ = 1'b1;
        end
        if (tok_in.remaining != '0)
        begin
            tok_next.remaining = tok_in.remaining - CNT_W'(1);
        end
        else if (tok_in.valid && tok_in.store)
        begin
            // first free slot reached: take the rectangle
            rect_next      = tok_in.rect;
            tok_next.store = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tok_reg  <= tok_next;
            rect_reg <= rect_next;
        end
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = valid_reg;
    end

endmodule

// ===== design/roc_tail.sv =====
// chain exit: running occluded count and output register
`include "rect_occlusion_cull_defines.svh"

module roc_tail import roc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  tok_t      tok_in,
    input  logic      cull_stall,
    output logic      en,
    output logic      cull_valid,
    output out_item_t cull
);

    logic       valid_reg;
    logic [6:0] total_reg;
    logic [6:0] total_base;
    logic [6:0] total_next;
    out_item_t  item_reg;
    out_item_t  item_next;
    logic       take;

    assign en   = !valid_reg || !cull_stall;
    assign take = en && tok_in.valid;

    always_comb
    begin
        total_base = tok_in.frame_start ? 7'd0 : total_reg;
        total_next = total_base;
        if (tok_in.occ && (total_base < TOTAL_MAX))
        begin
            total_next = total_base + 7'd1;
        end
        item_next.occluded        = tok_in.occ;
        item_next.occluded_so_far = total_next;
        item_next.store_full      = tok_in.full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            total_reg <= 7'd0;
        end
        else
        begin
            if (en)
            begin
                valid_reg <= tok_in.valid;
            end
            if (take)
            begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign cull_valid = valid_reg;
    assign cull       = item_reg;

    `ROC_ASSERT_NEXT(a_total_steps,
        take && !tok_in.frame_start && tok_in.occ && total_reg != TOTAL_MAX,
        total_reg == $past(total_reg) + 7'd1,
        "occluded count did not advance")
    `ROC_ASSERT_NOW(a_result_matches_total,
        cull_valid,
        cull.occluded_so_far == total_reg,
        "result count differs from running total")

endmodule
